[design/inverse_cdf_table_sampler_core_macros.svh]
// Assertion macros for the inverse CDF table sampler
`ifndef INVERSE_CDF_TABLE_SAMPLER_CORE_MACROS_SVH
`define INVERSE_CDF_TABLE_SAMPLER_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ICDF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent
`define ICDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/icdf_pkg.sv]
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and constants of the inverse CDF table sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package icdf_pkg;
    localparam int MAX_STEPS_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int TS_W    = 25;
    localparam int SUM_W   = 26;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = 25;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;
    localparam int WIN_W   = 16;
    localparam int RATIO_W = 25;
    localparam logic [TS_W-1:0] TS_RESET = 25'd16384;
    localparam logic [POS_W-1:0] ONE_Q24 = 25'h100_0000;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SAMPLE = 2'd2
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_SAMPLED  = 3'd0,
        ST_HIGH     = 3'd1,
        ST_LOW      = 3'd2,
        ST_APPENDED = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SRCH_RD, S_SRCH_WAIT, S_SRCH_CMP, S_RD_HI, S_RD_LO,
        S_RD_WAIT, S_RD_CAP, S_DIV_INIT, S_DIV, S_MUL, S_ADD, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic do_clear;
        logic do_append;
        logic srch_init;
        logic srch_rd;
        logic srch_cmp;
        logic rd_hi;
        logic rd_lo;
        logic cap_hi;
        logic cap_lo;
        logic div_init;
        logic div_step;
        logic mul;
        logic add;
        logic set_out;
        logic [STAT_W-1:0] status;
    } t_cmds;

    typedef struct packed {
        logic is_sample;
        logic is_append;
        logic full;
        logic srch_done;
        logic idx_high;
        logic idx_zero;
        logic div_done;
    } t_stat;
endpackage

[design/icdf_if.sv]
// ----------------------------------------------------------------------------
// icdf_in_if / icdf_out_if
// Valid/ready channels carrying sampler command and result words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface icdf_in_if;
    logic valid;
    logic ready;
    logic [icdf_pkg::CMD_W-1:0]  command;
    logic [icdf_pkg::WIN_W-1:0]  weight;
    logic [icdf_pkg::FRAC_W-1:0] fraction;
    modport source (output valid, command, weight, fraction, input ready);
    modport sink (input valid, command, weight, fraction, output ready);
endinterface

interface icdf_out_if;
    logic valid;
    logic ready;
    logic [icdf_pkg::POS_W-1:0]  position;
    logic [icdf_pkg::STAT_W-1:0] status;
    modport source (output valid, position, status, input ready);
    modport sink (input valid, position, status, output ready);
endinterface

[design/icdf_ctrl.sv]
// ----------------------------------------------------------------------------
// icdf_ctrl
// Sequencer: decode, binary search, interpolation, result handoff.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module icdf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_out_busy,
    output logic                o_out_load,
    input  icdf_pkg::t_stat     i_stat,
    output icdf_pkg::t_cmds     o_cmds
);
    icdf_pkg::t_state r_state, n_state;
    logic [icdf_pkg::STAT_W-1:0] r_status, n_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= icdf_pkg::S_IDLE;
            r_status <= icdf_pkg::ST_CLEARED;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        unique case (r_state)
            icdf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = icdf_pkg::S_DECODE;
            end
            icdf_pkg::S_DECODE: begin
                if (i_stat.is_sample) begin
                    n_state = icdf_pkg::S_SRCH_RD;
                end else if (i_stat.is_append) begin
                    n_status = i_stat.full ? icdf_pkg::ST_FULL : icdf_pkg::ST_APPENDED;
                    n_state  = icdf_pkg::S_OUT;
                end else begin
                    n_status = icdf_pkg::ST_CLEARED;
                    n_state  = icdf_pkg::S_OUT;
                end
            end
            icdf_pkg::S_SRCH_RD: begin
                if (i_stat.srch_done) begin
                    if (i_stat.idx_high) begin
                        n_status = icdf_pkg::ST_HIGH;
                        n_state  = icdf_pkg::S_OUT;
                    end else if (i_stat.idx_zero) begin
                        n_status = icdf_pkg::ST_LOW;
                        n_state  = icdf_pkg::S_OUT;
                    end else begin
                        n_state = icdf_pkg::S_RD_HI;
                    end
                end else begin
                    n_state = icdf_pkg::S_SRCH_WAIT;
                end
            end
            icdf_pkg::S_SRCH_WAIT: n_state = icdf_pkg::S_SRCH_CMP;
            icdf_pkg::S_SRCH_CMP:  n_state = icdf_pkg::S_SRCH_RD;
            icdf_pkg::S_RD_HI:     n_state = icdf_pkg::S_RD_LO;
            icdf_pkg::S_RD_LO:     n_state = icdf_pkg::S_RD_WAIT;
            icdf_pkg::S_RD_WAIT:   n_state = icdf_pkg::S_RD_CAP;
            icdf_pkg::S_RD_CAP:    n_state = icdf_pkg::S_DIV_INIT;
            icdf_pkg::S_DIV_INIT:  n_state = icdf_pkg::S_DIV;
            icdf_pkg::S_DIV: begin
                if (i_stat.div_done) n_state = icdf_pkg::S_MUL;
            end
            icdf_pkg::S_MUL: n_state = icdf_pkg::S_ADD;
            icdf_pkg::S_ADD: begin
                n_status = icdf_pkg::ST_SAMPLED;
                n_state  = icdf_pkg::S_OUT;
            end
            icdf_pkg::S_OUT: begin
                if (!i_out_busy) n_state = icdf_pkg::S_IDLE;
            end
            default: n_state = icdf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmds     = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        o_cmds.status = r_status;
        unique case (r_state)
            icdf_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmds.load = i_in_valid;
            end
            icdf_pkg::S_DECODE: begin
                o_cmds.srch_init = i_stat.is_sample;
                o_cmds.do_append = i_stat.is_append & ~i_stat.full;
                o_cmds.do_clear  = ~i_stat.is_sample & ~i_stat.is_append;
            end
            icdf_pkg::S_SRCH_RD:  o_cmds.srch_rd  = ~i_stat.srch_done;
            icdf_pkg::S_SRCH_CMP: o_cmds.srch_cmp = 1'b1;
            icdf_pkg::S_RD_HI:    o_cmds.rd_hi    = 1'b1;
            icdf_pkg::S_RD_LO:    o_cmds.rd_lo    = 1'b1;
            icdf_pkg::S_RD_WAIT:  o_cmds.cap_hi   = 1'b1;
            icdf_pkg::S_RD_CAP:   o_cmds.cap_lo   = 1'b1;
            icdf_pkg::S_DIV_INIT: o_cmds.div_init = 1'b1;
            icdf_pkg::S_DIV:      o_cmds.div_step = 1'b1;
            icdf_pkg::S_MUL:      o_cmds.mul      = 1'b1;
            icdf_pkg::S_ADD:      o_cmds.add      = 1'b1;
            icdf_pkg::S_OUT: begin
                o_cmds.set_out = ~i_out_busy;
                o_out_load     = ~i_out_busy;
            end
            default: ;
        endcase
    end
endmodule

[design/icdf_dp.sv]
// ----------------------------------------------------------------------------
// icdf_dp
// Datapath: cumulative table, search pointers, serial divider, interpolation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module icdf_dp #(
    parameter int MAX_STEPS   = icdf_pkg::MAX_STEPS_DEF,
    parameter int WEIGHT_BITS = icdf_pkg::WEIGHT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  icdf_pkg::t_cmds               i_cmds,
    output icdf_pkg::t_stat               o_stat,
    input  logic [icdf_pkg::CMD_W-1:0]    i_command,
    input  logic [icdf_pkg::WIN_W-1:0]    i_weight,
    input  logic [icdf_pkg::FRAC_W-1:0]   i_fraction,
    input  logic [icdf_pkg::TS_W-1:0]     i_time_step,
    output logic [icdf_pkg::POS_W-1:0]    o_position
);
    localparam int AW   = $clog2(MAX_STEPS);
    localparam int CW   = $clog2(MAX_STEPS + 1);
    localparam int SW   = icdf_pkg::SUM_W;
    localparam int TW   = SW + icdf_pkg::FRAC_W;
    localparam int NW   = TW + 8;
    localparam int RW   = icdf_pkg::RATIO_W;
    localparam int IDXW = CW + icdf_pkg::TS_W;
    localparam int WB   = (WEIGHT_BITS < icdf_pkg::WIN_W) ? WEIGHT_BITS : icdf_pkg::WIN_W;
    localparam logic [SW-1:0] TOTAL_MAX = '1;
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_STEPS);

    logic [SW-1:0] r_mem [MAX_STEPS];
    logic [SW-1:0] r_rd;
    logic [AW-1:0] r_rd_addr;

    logic [icdf_pkg::CMD_W-1:0]  r_cmd;
    logic [WB-1:0]               r_wt;
    logic [icdf_pkg::FRAC_W-1:0] r_frac;
    logic [CW-1:0]  r_count;
    logic [SW-1:0]  r_total;
    logic [TW-1:0]  r_target;
    logic [CW-1:0]  r_lo, r_hi, r_mid;
    logic [SW-1:0]  r_c_hi, r_c_lo;
    logic [NW-1:0]  r_rem_num;
    logic [SW:0]    r_rem;
    logic [RW-1:0]  r_quo;
    logic [5:0]     r_div_cnt;
    logic [RW+icdf_pkg::TS_W-1:0] r_prod;
    logic [IDXW-1:0] r_base;
    logic [icdf_pkg::POS_W-1:0] r_pos;

    logic [SW:0]   sum_ext;
    logic [SW-1:0] sum_sat;
    logic [SW-1:0] diff;
    logic [SW+1:0] trial;
    logic [IDXW:0] pos_sum;
    logic [CW-1:0] mid_c;

    assign sum_ext = {1'b0, r_total} + (SW+1)'(r_wt);
    assign sum_sat = sum_ext[SW] ? TOTAL_MAX : sum_ext[SW-1:0];
    assign diff    = r_c_hi - r_c_lo;
    assign trial   = {r_rem, r_rem_num[NW-1]} - {2'b00, diff};
    assign mid_c   = r_lo + ((r_hi - r_lo) >> 1);

    always_ff @(posedge i_clk) begin
        if (i_cmds.do_append) r_mem[r_count[AW-1:0]] <= sum_sat;
        r_rd <= r_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmds.do_clear) begin
            r_count <= '0;
            r_total <= '0;
        end else if (i_cmds.do_append) begin
            r_count <= r_count + CW'(1);
            r_total <= sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmds.load) begin
            r_cmd  <= i_command;
            r_wt   <= i_weight[WB-1:0];
            r_frac <= i_fraction;
        end
        if (i_cmds.srch_init) begin
            r_target <= TW'(r_total) * TW'(r_frac);
            r_lo <= '0;
            r_hi <= r_count;
        end
        if (i_cmds.srch_rd) begin
            r_mid     <= mid_c;
            r_rd_addr <= mid_c[AW-1:0];
        end
        if (i_cmds.srch_cmp) begin
            if ({r_rd, 16'h0} > r_target) r_hi <= r_mid;
            else r_lo <= r_mid + CW'(1);
        end
        if (i_cmds.rd_hi) r_rd_addr <= r_lo[AW-1:0];
        if (i_cmds.rd_lo) r_rd_addr <= AW'(r_lo - CW'(1));
        if (i_cmds.cap_hi) r_c_hi <= r_rd;
        if (i_cmds.cap_lo) r_c_lo <= r_rd;
        if (i_cmds.div_init) begin
            r_rem_num <= {(r_target - {r_c_lo, 16'h0}), 8'h0};
            r_rem     <= '0;
            r_quo     <= '0;
            r_div_cnt <= '0;
            r_base    <= IDXW'(r_lo - CW'(1)) * IDXW'(i_time_step);
        end
        if (i_cmds.div_step) begin
            r_rem_num <= r_rem_num << 1;
            r_div_cnt <= r_div_cnt + 6'd1;
            if (!trial[SW+1]) begin
                r_rem <= trial[SW:0];
                r_quo <= {r_quo[RW-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[SW-1:0], r_rem_num[NW-1]};
                r_quo <= {r_quo[RW-2:0], 1'b0};
            end
        end
        if (i_cmds.mul) r_prod <= (diff == '0 ? RW'(0) : r_quo) * i_time_step;
        if (i_cmds.add) begin
            if (pos_sum > (IDXW+1)'(icdf_pkg::ONE_Q24)) r_pos <= icdf_pkg::ONE_Q24;
            else r_pos <= pos_sum[icdf_pkg::POS_W-1:0];
        end
    end

    assign pos_sum = {1'b0, r_base} + (IDXW+1)'(r_prod >> 24);

    always_comb begin
        o_stat.is_sample = r_cmd[1];
        o_stat.is_append = (r_cmd == icdf_pkg::CMD_APPEND);
        o_stat.full      = (r_count >= FULL_CNT);
        o_stat.srch_done = (r_lo >= r_hi);
        o_stat.idx_high  = (r_lo >= r_count);
        o_stat.idx_zero  = (r_lo == '0);
        o_stat.div_done  = (r_div_cnt == 6'(NW - 1));
    end

    assign o_position = r_pos;
endmodule

[design/inverse_cdf_table_sampler_core.sv]
// ----------------------------------------------------------------------------
// Inverse CDF table sampler core
// Builds a cumulative weight table and draws positions by inverse transform.
//
// channel   dir   handshake        word
// in        in    valid/ready      command, weight, fraction
// out       out   valid/ready      position, status
// cfg       in    APB write/read   time_step at 0x0
//
// Clear and append pass through decode to the output state; a sample runs
// a binary search of up to log2(count)+1 probes, then, if not clamped, interpolates.
// Sample time is set by the search loop over the table memory
// (one registered read per probe) and the 50-step one-bit-per-cycle divider.
// Reset is synchronous: the count and total clear, table contents do not.
// A result waits in the output register; a stalled sink holds the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module inverse_cdf_table_sampler_core #(
    parameter int MAX_STEPS   = icdf_pkg::MAX_STEPS_DEF,
    parameter int WEIGHT_BITS = icdf_pkg::WEIGHT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    icdf_in_if.sink     i_in,
    icdf_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam logic [1:0] REG_TIME_STEP = 2'd0;

    logic [icdf_pkg::TS_W-1:0] r_time_step;
    logic r_out_valid;
    logic [icdf_pkg::POS_W-1:0]  r_out_pos;
    logic [icdf_pkg::STAT_W-1:0] r_out_stat;
    icdf_pkg::t_cmds cmds;
    icdf_pkg::t_stat stat;
    logic out_load;
    logic [icdf_pkg::POS_W-1:0] dp_pos;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_TIME_STEP) ? 32'(r_time_step) : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= icdf_pkg::TS_RESET;
        end else if (psel && penable && pwrite && paddr == REG_TIME_STEP) begin
            r_time_step <= pwdata[icdf_pkg::TS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_stat <= cmds.status;
            r_out_pos  <= (cmds.status == icdf_pkg::ST_SAMPLED) ? dp_pos :
                          (cmds.status == icdf_pkg::ST_HIGH) ? icdf_pkg::ONE_Q24 : '0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_out_pos;
    assign o_out.status   = r_out_stat;

    icdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_out_busy (r_out_valid & ~o_out.ready),
        .o_out_load (out_load),
        .i_stat     (stat),
        .o_cmds     (cmds)
    );

    icdf_dp #(
        .MAX_STEPS   (MAX_STEPS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmds      (cmds),
        .o_stat      (stat),
        .i_command   (i_in.command),
        .i_weight    (i_in.weight),
        .i_fraction  (i_in.fraction),
        .i_time_step (r_time_step),
        .o_position  (dp_pos)
    );
endmodule

[design/icdf_checker.sv]
// ----------------------------------------------------------------------------
// icdf_checker
// Port-level checks of the sampler core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inverse_cdf_table_sampler_core_macros.svh"
module icdf_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [icdf_pkg::POS_W-1:0]    i_out_position,
    input logic [icdf_pkg::STAT_W-1:0]   i_out_status
);
    logic stat_high;
    logic stat_zero;
    logic out_stall;

    assign stat_high = (i_out_status == icdf_pkg::ST_HIGH);
    assign stat_zero = (i_out_status != icdf_pkg::ST_SAMPLED) && !stat_high;
    assign out_stall = i_out_valid && !i_out_ready;

    `ICDF_ASSERT_IMPL(a_pos_range, i_clk, i_rst_n, i_out_valid, i_out_position <= icdf_pkg::ONE_Q24)
    `ICDF_ASSERT_IMPL(a_high_one, i_clk, i_rst_n, i_out_valid && stat_high, i_out_position == icdf_pkg::ONE_Q24)
    `ICDF_ASSERT_IMPL(a_nonsample_zero, i_clk, i_rst_n, i_out_valid && stat_zero, i_out_position == '0)
    `ICDF_ASSERT_NEXT(a_one_at_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    `ICDF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(i_out_status))
endmodule

bind inverse_cdf_table_sampler_core icdf_checker u_icdf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_position (o_out.position),
    .i_out_status   (o_out.status)
);
